// ----- hw/rtl/tbsd_pkg.sv -----
`default_nettype none

package tbsd_pkg;

   localparam int MaxSymbolBytes = 6;
   localparam int SymbolBytes    = 6;

   localparam logic [7:0] EscByte   = 8'h1B;
   localparam logic [7:0] TabByte   = 8'h09;
   localparam logic [7:0] BsByte    = 8'h08;
   localparam logic [7:0] NlByte    = 8'h0A;
   localparam logic [7:0] SpaceByte = 8'h20;
   localparam logic [7:0] CtrlBias  = 8'h40;
   localparam logic [7:0] AllOnes   = 8'hFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       key_pending;
      logic       clear_escapes;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [47:0] symbol_bytes;
      logic [2:0]  symbol_length;
      logic        ctrl_mod;
      logic        meta_mod;
      logic [7:0]  escape_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  expected_length;
      logic [2:0]  collected_count;
      logic [47:0] partial_symbol;
      logic        pending_meta;
      logic [7:0]  escape_counter;
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tbsd_req_if.sv -----
`default_nettype none

interface tbsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       key_pending;
   logic       clear_escapes;

   modport source (output valid, output in_byte, output key_pending,
                   output clear_escapes, input ready);
   modport sink (input valid, input in_byte, input key_pending,
                 input clear_escapes, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbsd_rsp_if.sv -----
`default_nettype none

interface tbsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [47:0] symbol_bytes;
   logic [2:0]  symbol_length;
   logic        ctrl_mod;
   logic        meta_mod;
   logic [7:0]  escape_count;
   logic        last;

   modport source (output valid, output result_kind, output symbol_bytes,
                   output symbol_length, output ctrl_mod, output meta_mod,
                   output escape_count, output last, input ready);
   modport sink (input valid, input result_kind, input symbol_bytes,
                 input symbol_length, input ctrl_mod, input meta_mod,
                 input escape_count, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/terminal_byte_symbol_decoder.sv -----
`default_nettype none

// Terminal byte decoder: one raw byte per request is registered, decoded
// against the open-sequence state and pushed into a two-entry result
// buffer. The byte passes through the input register and then the result
// buffer before its first result is offered; a byte that cuts short an
// open multibyte sequence gives two results, and since the result buffer
// drains one entry a cycle when ready, such a byte waits for two free slots.
module terminal_byte_symbol_decoder (
   input wire logic clock,
   input wire logic reset,
   tbsd_req_if.sink   req_chan,
   tbsd_rsp_if.source rsp_chan
);
   import tbsd_pkg::*;

   logic       in_valid_ff;
   req_type    in_ff;
   state_type  state_ff;
   state_type  state_in;
   rsp_type    slot_ff [2];
   rsp_type    slot_in [2];
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic [1:0] base;
   logic [1:0] free;
   logic [1:0] need;
   logic       pop;
   logic       fire;
   logic       two;
   rsp_type    first;
   rsp_type    second;
   req_type    req_item;

   assign req_item.in_byte       = req_chan.in_byte;
   assign req_item.key_pending   = req_chan.key_pending;
   assign req_item.clear_escapes = req_chan.clear_escapes;

   tbsd_decode u_decode (
      .state      (state_ff),
      .item       (in_ff),
      .state_next (state_in),
      .first      (first),
      .second     (second),
      .two        (two)
   );

   assign pop  = (fill_ff != 2'd0) && rsp_chan.ready;
   assign base = fill_ff - {1'b0, pop};
   assign free = 2'd2 - base;
   assign need = two ? 2'd2 : 2'd1;
   assign fire = in_valid_ff && (free >= need);

   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (fire) begin
         if (base == 2'd0) begin
            slot_in[0] = first;
            slot_in[1] = second;
         end else begin
            slot_in[1] = first;
         end
      end
      fill_in = base + (fire ? need : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         fill_ff                  <= 2'd0;
         state_ff.expected_length <= 3'd0;
         state_ff.collected_count <= 3'd0;
         state_ff.pending_meta    <= 1'b0;
         state_ff.escape_counter  <= 8'd0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         fill_ff <= fill_in;
         if (fire) begin
            state_ff.expected_length <= state_in.expected_length;
            state_ff.collected_count <= state_in.collected_count;
            state_ff.partial_symbol  <= state_in.partial_symbol;
            state_ff.pending_meta    <= state_in.pending_meta;
            state_ff.escape_counter  <= state_in.escape_counter;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff <= req_item;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_chan.valid         = fill_ff != 2'd0;
   assign rsp_chan.result_kind   = slot_ff[0].result_kind;
   assign rsp_chan.symbol_bytes  = slot_ff[0].symbol_bytes;
   assign rsp_chan.symbol_length = slot_ff[0].symbol_length;
   assign rsp_chan.ctrl_mod      = slot_ff[0].ctrl_mod;
   assign rsp_chan.meta_mod      = slot_ff[0].meta_mod;
   assign rsp_chan.escape_count  = slot_ff[0].escape_count;
   assign rsp_chan.last          = slot_ff[0].last;

endmodule

`default_nettype wire

// ----- hw/rtl/tbsd_decode.sv -----
`default_nettype none

module tbsd_decode (
   input  tbsd_pkg::state_type state,
   input  tbsd_pkg::req_type   item,
   output tbsd_pkg::state_type state_next,
   output tbsd_pkg::rsp_type   first,
   output tbsd_pkg::rsp_type   second,
   output logic                two
);
   import tbsd_pkg::*;

   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   logic [7:0]  c;
   logic [7:0]  cc;
   logic [7:0]  esc_base;
   logic [7:0]  esc_sat;
   logic [3:0]  n_ones;
   logic [2:0]  cnt_new;
   logic [47:0] partial_new;
   logic        open_seq;
   logic        cont;
   logic        strip;
   logic        meta_in;
   logic        meta_f;
   rsp_type     incomplete;
   rsp_type     fresh;
   state_type   fresh_state;

   assign c        = item.in_byte;
   assign esc_base = item.clear_escapes ? 8'd0 : state.escape_counter;
   assign esc_sat  = (esc_base == AllOnes) ? esc_base : esc_base + 8'd1;
   assign open_seq = state.expected_length != 3'd0;
   assign cont     = c[7:6] == 2'b10;
   assign two      = open_seq && !cont;
   assign n_ones   = lead_ones(cc);

   // Fresh decode of the byte, with the cut-short symbol already taken out
   always_comb begin
      meta_in = two ? 1'b0 : state.pending_meta;
      strip   = c[7] && !(c[7:6] == 2'b11 && c != AllOnes);
      cc      = strip ? {1'b0, c[6:0]} : c;
      meta_f  = meta_in | strip;

      incomplete              = '0;
      incomplete.escape_count = esc_base;
      incomplete.last         = 1'b1;

      fresh_state                 = state;
      fresh_state.expected_length = 3'd0;
      fresh_state.collected_count = 3'd0;
      fresh_state.pending_meta    = 1'b0;
      fresh_state.escape_counter  = esc_base;

      fresh               = '0;
      fresh.result_kind   = 1'b1;
      fresh.symbol_bytes  = {40'd0, cc};
      fresh.symbol_length = 3'd1;
      fresh.meta_mod      = meta_f;
      fresh.escape_count  = esc_base;
      fresh.last          = 1'b1;

      if (cc == EscByte && !item.key_pending) begin
         fresh_state.escape_counter = esc_sat;
         fresh_state.pending_meta   = meta_f;
         fresh                      = incomplete;
         fresh.escape_count         = esc_sat;
      end else if (cc == 8'd0) begin
         fresh.symbol_bytes = {40'd0, SpaceByte};
         fresh.ctrl_mod     = 1'b1;
      end else if (cc < SpaceByte && cc != TabByte && cc != BsByte && cc != NlByte) begin
         fresh.symbol_bytes = {40'd0, cc + CtrlBias};
         fresh.ctrl_mod     = 1'b1;
      end else if (cc[7:6] == 2'b11 && n_ones <= 4'(MaxSymbolBytes)) begin
         // open a multibyte symbol
         fresh_state.expected_length = n_ones[2:0];
         fresh_state.collected_count = 3'd1;
         fresh_state.partial_symbol  = {40'd0, cc};
         fresh_state.pending_meta    = meta_f;
         fresh                       = incomplete;
      end
   end

   // Continuation byte or cut-short sequence
   always_comb begin
      partial_new = state.partial_symbol;
      for (int i = 1; i < SymbolBytes; i++) begin
         if (state.collected_count == 3'(i)) begin
            partial_new[8*i +: 8] = c;
         end
      end
      cnt_new = (state.collected_count < 3'(SymbolBytes)) ?
                state.collected_count + 3'd1 : state.collected_count;

      first  = fresh;
      second = fresh;
      state_next = fresh_state;

      if (two) begin
         first.result_kind   = 1'b1;
         first.symbol_bytes  = state.partial_symbol;
         first.symbol_length = state.collected_count;
         first.ctrl_mod      = 1'b0;
         first.meta_mod      = state.pending_meta;
         first.escape_count  = esc_base;
         first.last          = 1'b0;
      end else if (open_seq) begin
         state_next                 = state;
         state_next.escape_counter  = esc_base;
         state_next.partial_symbol  = partial_new;
         state_next.collected_count = cnt_new;
         first                      = incomplete;
         if (cnt_new >= state.expected_length) begin
            state_next.expected_length = 3'd0;
            state_next.collected_count = 3'd0;
            state_next.pending_meta    = 1'b0;
            first.result_kind          = 1'b1;
            first.symbol_bytes         = partial_new;
            first.symbol_length        = cnt_new;
            first.meta_mod             = state.pending_meta;
         end
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb_terminal_byte_symbol_decoder.sv -----
`timescale 1ns / 100ps

module tb_terminal_byte_symbol_decoder;
   import tbsd_pkg::*;

   localparam int StallLimit     = 5000;
   localparam int SettleCycles   = 12;
   localparam int MaxShown       = 30;
   localparam int PhaseItems     = 120;
   localparam int EscBurst       = 260;

   logic clock;
   logic reset;

   tbsd_req_if req_chan ();
   tbsd_rsp_if rsp_chan ();

   terminal_byte_symbol_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Tracks decoder state and holds the symbols each request should produce.
   class symbol_scoreboard;
      rsp_type     symbol_q[$];
      int unsigned error_count;
      logic [2:0]  open_length;
      logic [2:0]  held_count;
      logic [47:0] held_bytes;
      logic        meta_pending;
      logic [7:0]  esc_count;

      function new();
         error_count  = 0;
         open_length  = '0;
         held_count   = '0;
         held_bytes   = '0;
         meta_pending = 1'b0;
         esc_count    = '0;
      endfunction

      function string show_rsp(rsp_type r);
         return $sformatf("kind %0b bytes %012h len %0d ctrl %0b meta %0b esc %0d last %0b",
                          r.result_kind, r.symbol_bytes, r.symbol_length, r.ctrl_mod,
                          r.meta_mod, r.escape_count, r.last);
      endfunction

      function void push_result(logic kind, logic [47:0] bytes, logic [2:0] len,
                                logic ctrl, logic is_last);
         rsp_type r;
         r.result_kind   = kind;
         r.symbol_bytes  = bytes;
         r.symbol_length = len;
         r.ctrl_mod      = ctrl;
         r.meta_mod      = kind ? meta_pending : 1'b0;
         r.escape_count  = esc_count;
         r.last          = is_last;
         // a completed symbol consumes the meta modifier
         if (kind)
            meta_pending = 1'b0;
         symbol_q.push_back(r);
      endfunction

      function void decode_byte(logic [7:0] b, logic key);
         int ones;
         if (b[7] && !(b[7:6] == 2'b11 && b != AllOnes)) begin
            b[7] = 1'b0;
            meta_pending = 1'b1;
         end
         if (b == EscByte && !key) begin
            if (esc_count != AllOnes)
               esc_count = esc_count + 8'd1;
            push_result(1'b0, '0, '0, 1'b0, 1'b1);
         end else if (b == 8'h00) begin
            push_result(1'b1, 48'(SpaceByte), 3'd1, 1'b1, 1'b1);
         end else if (b < SpaceByte && b != TabByte && b != BsByte && b != NlByte) begin
            push_result(1'b1, 48'(8'(b + CtrlBias)), 3'd1, 1'b1, 1'b1);
         end else if (b[7:6] == 2'b11) begin
            ones = 0;
            while (ones < 8 && b[7 - ones])
               ones++;
            if (ones > MaxSymbolBytes) begin
               push_result(1'b1, 48'(b), 3'd1, 1'b0, 1'b1);
            end else begin
               open_length = 3'(ones);
               held_count  = 3'd1;
               held_bytes  = 48'(b);
               push_result(1'b0, '0, '0, 1'b0, 1'b1);
            end
         end else begin
            push_result(1'b1, 48'(b), 3'd1, 1'b0, 1'b1);
         end
      endfunction

      function void note_request(req_type r);
         if (r.clear_escapes)
            esc_count = '0;
         if (open_length == 0) begin
            decode_byte(r.in_byte, r.key_pending);
         end else if (r.in_byte[7:6] != 2'b10) begin
            // cut short: flush the partial symbol, then decode the byte afresh
            push_result(1'b1, held_bytes, held_count, 1'b0, 1'b0);
            open_length = '0;
            held_count  = '0;
            decode_byte(r.in_byte, r.key_pending);
         end else begin
            held_bytes[int'(held_count) * 8 +: 8] = r.in_byte;
            held_count = held_count + 3'd1;
            if (held_count >= open_length) begin
               push_result(1'b1, held_bytes, held_count, 1'b0, 1'b1);
               open_length = '0;
               held_count  = '0;
            end else begin
               push_result(1'b0, '0, '0, 1'b0, 1'b1);
            end
         end
      endfunction

      task report_mismatch(string msg);
         error_count++;
         if (error_count <= MaxShown)
            $display("mismatch: %s", msg);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (symbol_q.size() == 0) begin
            report_mismatch({"unexpected response: ", show_rsp(got)});
            return;
         end
         want = symbol_q.pop_front();
         if (got.result_kind !== want.result_kind || got.symbol_bytes !== want.symbol_bytes ||
             got.symbol_length !== want.symbol_length || got.ctrl_mod !== want.ctrl_mod ||
             got.meta_mod !== want.meta_mod || got.escape_count !== want.escape_count ||
             got.last !== want.last)
            report_mismatch({"got ", show_rsp(got), " expected ", show_rsp(want)});
      endtask
   endclass

   symbol_scoreboard sb;
   int               send_idle_pct;
   int               rsp_stall_pct;
   int               sent_count;
   int               stuck_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Monitor: sample both channels at the edge, before any update lands.
   always @(posedge clock) begin
      req_type seen_req;
      rsp_type seen_rsp;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_req.in_byte       = req_chan.in_byte;
            seen_req.key_pending   = req_chan.key_pending;
            seen_req.clear_escapes = req_chan.clear_escapes;
            sb.note_request(seen_req);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp.result_kind   = rsp_chan.result_kind;
            seen_rsp.symbol_bytes  = rsp_chan.symbol_bytes;
            seen_rsp.symbol_length = rsp_chan.symbol_length;
            seen_rsp.ctrl_mod      = rsp_chan.ctrl_mod;
            seen_rsp.meta_mod      = rsp_chan.meta_mod;
            seen_rsp.escape_count  = rsp_chan.escape_count;
            seen_rsp.last          = rsp_chan.last;
            sb.check_response(seen_rsp);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task send_byte(input logic [7:0] b, input logic key, input logic clr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.in_byte       <= b;
      req_chan.key_pending   <= key;
      req_chan.clear_escapes <= clr;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sent_count++;
   endtask

   task send_random_item();
      int         pick;
      int         seq_len;
      int         upto;
      logic [7:0] lead;
      pick = $urandom_range(99);
      if (pick < 45) begin
         // well-formed multibyte symbol, sometimes cut short by the next request
         seq_len = ($urandom_range(3) == 0) ? $urandom_range(2, 6) : $urandom_range(2, 3);
         lead = 8'(8'hFF << (8 - seq_len)) | (8'($urandom) & 8'(8'hFF >> (seq_len + 1)));
         upto = seq_len;
         if ($urandom_range(4) == 0)
            upto = $urandom_range(1, seq_len - 1);
         send_byte(lead, $urandom_range(3) == 0, $urandom_range(9) == 0);
         for (int i = 1; i < upto; i++)
            send_byte({2'b10, 6'($urandom)}, $urandom_range(3) == 0, $urandom_range(9) == 0);
      end else if (pick < 60) begin
         repeat ($urandom_range(1, 3))
            send_byte(EscByte, $urandom_range(4) == 0, $urandom_range(9) == 0);
      end else begin
         send_byte(8'($urandom), $urandom_range(1) == 0, $urandom_range(9) == 0);
      end
   endtask

   task wait_drained();
      do
         @(posedge clock);
      while (sb.symbol_q.size() != 0);
   endtask

   initial begin
      int target;
      sb                     = new();
      send_idle_pct          = 0;
      rsp_stall_pct          = 0;
      sent_count             = 0;
      stuck_cycles           = 0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.in_byte       = '0;
      req_chan.key_pending   = 1'b0;
      req_chan.clear_escapes = 1'b0;
      rsp_chan.ready         = 1'b0;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 64;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 64;
            end
            default: begin
               send_idle_pct = 35;
               rsp_stall_pct = 35;
            end
         endcase

         if (phase == 0) begin
            send_byte(8'h00, 1'b0, 1'b0);
            send_byte(8'h01, 1'b0, 1'b0);
            send_byte(TabByte, 1'b0, 1'b0);
            send_byte(BsByte, 1'b0, 1'b0);
            send_byte(NlByte, 1'b0, 1'b0);
            send_byte(8'h7F, 1'b0, 1'b0);
            send_byte(EscByte, 1'b0, 1'b0);
            send_byte(EscByte, 1'b0, 1'b0);
            send_byte(EscByte, 1'b1, 1'b0);
            send_byte(8'h41, 1'b0, 1'b1);
            // meta ESC: count bumps and meta waits for the next symbol
            send_byte(8'h9B, 1'b0, 1'b0);
            send_byte(8'h80, 1'b0, 1'b0);
            send_byte(8'hBF, 1'b0, 1'b0);
            send_byte(AllOnes, 1'b1, 1'b1);
            send_byte(8'hFE, 1'b0, 1'b0);
            send_byte(8'hFC, 1'b0, 1'b0);
            send_byte(8'h80, 1'b0, 1'b0);
            send_byte(8'h81, 1'b0, 1'b0);
            send_byte(8'hA2, 1'b0, 1'b0);
            send_byte(8'h93, 1'b0, 1'b0);
            send_byte(8'hBF, 1'b0, 1'b0);
            send_byte(8'hE2, 1'b0, 1'b0);
            send_byte(8'h82, 1'b0, 1'b0);
            send_byte(8'hC3, 1'b0, 1'b0);
            send_byte(8'hA9, 1'b0, 1'b0);
            send_byte(8'hE2, 1'b0, 1'b0);
            send_byte(8'h1F, 1'b0, 1'b0);
            // long ESC run to saturate the escape count
            send_byte(EscByte, 1'b0, 1'b1);
            repeat (EscBurst - 1)
               send_byte(EscByte, 1'b0, 1'b0);
            send_byte(8'h61, 1'b0, 1'b0);
         end

         target = sent_count + PhaseItems;
         while (sent_count < target)
            send_random_item();
         req_chan.valid <= 1'b0;
         wait_drained();
      end

      repeat (SettleCycles)
         @(posedge clock);
      if (sb.symbol_q.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.symbol_q.size()));
      if (sb.error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
